// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define CHS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// chs_pkg
// types and constants of the chs task-file command issue block
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int SECTOR_BYTES   = 512;
    localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);
    localparam int MAX_XFER_BYTES = 16384;

    localparam int OFF_W   = 32;
    localparam int LEN_W   = 31;
    localparam int SEC_W   = 32;
    localparam int LSEC_W  = SEC_W + 1;
    localparam int CAP_W   = $clog2(MAX_XFER_BYTES + SECTOR_BYTES);
    localparam int NSEC_W  = $clog2(MAX_XFER_BYTES / SECTOR_BYTES + 1);
    localparam int BYTES_W = 15;
    localparam int SPT_W   = 8;
    localparam int HPC_W   = 5;
    localparam int CNT_W   = $clog2(LSEC_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_SPT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HPC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE = 2'd2;

    localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
    localparam logic [HPC_W-1:0] HPC_RESET = 5'd16;

    localparam logic [2:0] PORT_COUNT    = 3'd2;
    localparam logic [2:0] PORT_SECTOR   = 3'd3;
    localparam logic [2:0] PORT_CYL_LOW  = 3'd4;
    localparam logic [2:0] PORT_CYL_HIGH = 3'd5;
    localparam logic [2:0] PORT_DRV_HEAD = 3'd6;
    localparam logic [2:0] PORT_COMMAND  = 3'd7;
    localparam logic [2:0] PORT_NONE     = 3'd0;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] DH_FIXED  = 8'h20;

    localparam logic [1:0] STATUS_ISSUED   = 2'd0;
    localparam logic [1:0] STATUS_PAST_END = 2'd1;
    localparam logic [1:0] STATUS_OFFLINE  = 2'd2;

    localparam logic [2:0] LAST_WRITE = 3'd5;

    typedef enum logic [1:0] {
        KIND_ISSUE,
        KIND_PAST,
        KIND_OFFLINE
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic               cmd;
        logic               drv;
        logic [LSEC_W-1:0]  lsec;
        logic [SEC_W-1:0]   pend;
        logic [NSEC_W-1:0]  nsec;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [LSEC_W-1:0]  dividend;
        logic [SPT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LSEC_W-1:0]  quotient;
        logic [SPT_W-1:0]   remainder;
    } div_rsp_t;

endpackage

// ----- hw/rtl/chs_front.sv -----
// ----------------------------------------------------------------------------
// chs_front
// takes requests, forms the logical sector and sector count, classifies them
// ----------------------------------------------------------------------------
module chs_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [chs_pkg::OFF_W-1:0] byte_offset,
    input  logic [chs_pkg::LEN_W-1:0] byte_length,
    input  logic [chs_pkg::SEC_W-1:0] part_start_sector,
    input  logic [chs_pkg::SEC_W-1:0] part_end_sector,
    input  logic                      drive_select,
    input  logic                      drive_online,
    input  logic                      fifo_full,
    output logic                      push,
    output chs_pkg::entry_t           entry
);
    import chs_pkg::*;

    logic [CAP_W-1:0]  len_cap;
    logic [CAP_W-1:0]  len_round;
    logic [LSEC_W-1:0] lsec;
    logic              past;

    always_comb
    begin
        if (byte_length > LEN_W'(MAX_XFER_BYTES))
            len_cap = CAP_W'(MAX_XFER_BYTES);
        else
            len_cap = byte_length[CAP_W-1:0];
        len_round = len_cap + CAP_W'(SECTOR_BYTES - 1);
        lsec = LSEC_W'(byte_offset >> SECTOR_SHIFT) + {1'b0, part_start_sector};
        past = lsec >= {1'b0, part_end_sector};
    end

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        entry.cmd  = cmd;
        entry.drv  = drive_select;
        entry.lsec = lsec;
        entry.pend = part_end_sector;
        entry.nsec = len_round[CAP_W-1 -: NSEC_W];
        if (!drive_online)
            entry.kind = KIND_OFFLINE;
        else if (past)
            entry.kind = KIND_PAST;
        else
            entry.kind = KIND_ISSUE;
    end

endmodule

// ----- hw/rtl/chs_fifo.sv -----
// ----------------------------------------------------------------------------
// chs_fifo
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module chs_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  chs_pkg::entry_t wr_entry,
    input  logic            pop,
    output chs_pkg::entry_t rd_entry,
    output logic            full,
    output logic            empty
);
    import chs_pkg::*;
    `include "assert_macros.svh"

    entry_t                    mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [FIFO_PTR_W:0]       count_reg;

    assign full     = count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `CHS_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
    `CHS_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
    `CHS_ASSERT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0], "pointer gap")

endmodule

// ----- hw/rtl/chs_divider.sv -----
// ----------------------------------------------------------------------------
// chs_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module chs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  chs_pkg::div_req_t req,
    output chs_pkg::div_rsp_t rsp
);
    import chs_pkg::*;

    logic [LSEC_W-1:0] q_reg;
    logic [SPT_W-1:0]  rem_reg;
    logic [SPT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SPT_W:0]    rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[LSEC_W-1]};
        ge     = rem_sh >= {1'b0, div_reg};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[LSEC_W-2:0], ge};
            if (ge)
                rem_reg <= SPT_W'(rem_sh - {1'b0, div_reg});
            else
                rem_reg <= rem_sh[SPT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(LSEC_W - 1)) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LSEC_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- hw/rtl/chs_back.sv -----
// ----------------------------------------------------------------------------
// chs_back
// geometry conversion and task-file write sequencer with output register
// ----------------------------------------------------------------------------
module chs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fifo_empty,
    input  chs_pkg::entry_t               entry,
    output logic                          pop,
    input  logic [chs_pkg::SPT_W-1:0]     sectors_per_track,
    input  logic [chs_pkg::HPC_W-1:0]     heads_per_cylinder,
    output chs_pkg::div_req_t             div_req,
    input  chs_pkg::div_rsp_t             div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    port_offset,
    output logic [7:0]                    reg_value,
    output logic [1:0]                    status,
    output logic [chs_pkg::BYTES_W-1:0]   byte_count,
    output logic                          last
);
    import chs_pkg::*;
    `include "assert_macros.svh"

    back_state_t        state_reg, state_next;
    logic [2:0]         idx_reg, idx_next;
    logic               cmd_reg, drv_reg;
    logic [NSEC_W-1:0]  nsec_reg;
    logic [SPT_W-1:0]   sec_reg;
    logic [HPC_W-1:0]   head_reg;
    logic [15:0]        cyl_reg;

    logic               out_valid_reg;
    logic [2:0]         port_reg;
    logic [7:0]         value_reg;
    logic [1:0]         status_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic               last_reg;

    logic               slot_free;
    logic               load_entry, save_r1, save_q2, load_out;
    logic [2:0]         o_port;
    logic [7:0]         o_value;
    logic [1:0]         o_status;
    logic               o_last;
    logic [LSEC_W-1:0]  sectors_left;
    logic [NSEC_W-1:0]  nsec_clip;
    logic [SPT_W-1:0]   spt_eff;
    logic [HPC_W-1:0]   hpc_eff;
    logic               div_phase;
    logic               reject_out;

    assign slot_free = !out_valid_reg || out_ready;
    assign spt_eff   = (sectors_per_track == '0) ? SPT_W'(1) : sectors_per_track;
    assign hpc_eff   = (heads_per_cylinder == '0) ? HPC_W'(1) : heads_per_cylinder;

    // sectors left before the partition end
    always_comb
    begin
        sectors_left = {1'b0, entry.pend} - entry.lsec;
        if (sectors_left[LSEC_W-1:NSEC_W] == '0 && sectors_left[NSEC_W-1:0] < entry.nsec)
            nsec_clip = sectors_left[NSEC_W-1:0];
        else
            nsec_clip = entry.nsec;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        load_entry = 1'b0;
        save_r1    = 1'b0;
        save_q2    = 1'b0;
        load_out   = 1'b0;
        div_req    = '0;
        o_port     = PORT_NONE;
        o_value    = '0;
        o_status   = STATUS_ISSUED;
        o_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    if (entry.kind == KIND_ISSUE)
                    begin
                        pop              = 1'b1;
                        load_entry       = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = entry.lsec;
                        div_req.divisor  = spt_eff;
                        state_next       = ST_DIV1;
                    end
                    else if (slot_free)
                    begin
                        pop      = 1'b1;
                        load_out = 1'b1;
                        o_status = (entry.kind == KIND_PAST) ? STATUS_PAST_END : STATUS_OFFLINE;
                        o_last   = 1'b1;
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_rsp.done)
                begin
                    save_r1          = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = SPT_W'(hpc_eff);
                    state_next       = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_rsp.done)
                begin
                    save_q2    = 1'b1;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out = 1'b1;
                    case (idx_reg)
                        3'd0:
                        begin
                            o_port  = PORT_COUNT;
                            o_value = 8'(nsec_reg);
                        end
                        3'd1:
                        begin
                            o_port  = PORT_SECTOR;
                            o_value = sec_reg;
                        end
                        3'd2:
                        begin
                            o_port  = PORT_DRV_HEAD;
                            o_value = DH_FIXED | {3'b000, drv_reg, 4'b0000} | 8'(head_reg);
                        end
                        3'd3:
                        begin
                            o_port  = PORT_CYL_LOW;
                            o_value = cyl_reg[7:0];
                        end
                        3'd4:
                        begin
                            o_port  = PORT_CYL_HIGH;
                            o_value = cyl_reg[15:8];
                        end
                        default:
                        begin
                            o_port  = PORT_COMMAND;
                            o_value = cmd_reg ? CMD_WRITE : CMD_READ;
                            o_last  = 1'b1;
                        end
                    endcase
                    if (idx_reg == LAST_WRITE)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_entry)
        begin
            cmd_reg  <= entry.cmd;
            drv_reg  <= entry.drv;
            nsec_reg <= nsec_clip;
        end
        if (save_r1)
            sec_reg <= div_rsp.remainder + 1'b1;
        if (save_q2)
        begin
            head_reg <= div_rsp.remainder[HPC_W-1:0];
            cyl_reg  <= div_rsp.quotient[15:0];
        end
        if (load_out)
        begin
            port_reg   <= o_port;
            value_reg  <= o_value;
            status_reg <= o_status;
            last_reg   <= o_last;
            if (o_status == STATUS_ISSUED)
                bytes_reg <= BYTES_W'({nsec_reg, {SECTOR_SHIFT{1'b0}}});
            else
                bytes_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign port_offset = port_reg;
    assign reg_value   = value_reg;
    assign status      = status_reg;
    assign byte_count  = bytes_reg;
    assign last        = last_reg;

    assign div_phase  = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
    assign reject_out = out_valid_reg && (status_reg != STATUS_ISSUED);

    `CHS_ASSERT(a_status_last, reject_out |-> last_reg, "status without last")
    `CHS_ASSERT(a_done_in_div, div_rsp.done |-> div_phase, "stray divide done")
    `CHS_ASSERT_NEVER(a_pop_busy, pop && state_reg != ST_IDLE, "pop while busy")

endmodule

// ----- hw/rtl/chs_transfer_command_issue.sv -----
// ----------------------------------------------------------------------------
// chs_transfer_command_issue
// turns a partition byte transfer request into six ata chs task-file writes
// ----------------------------------------------------------------------------
// usage
// - request channel in_valid/in_ready with cmd, byte_offset, byte_length,
//   part_start_sector, part_end_sector and drive_select; one transfer per request
// - result channel out_valid/out_ready with port_offset, reg_value, status,
//   byte_count and last; last marks the final result of a request
// - config port cfg_we/cfg_index/cfg_wdata: 0 sectors per track, 1 heads per
//   cylinder, 2 drive online; write only while the block is idle
// - an issued request gives six writes after two 33-step serial divisions
//   (sector by track, then track by heads)
// - offline or past-end requests give one status result through the output register
// - the back takes a new request from the queue only once the previous one is through
// - a two-entry queue lets the front keep taking requests while the back works
// - reset empties the queue and output register and loads geometry 63/16, offline
// - when the receiver stalls the output register holds and the back waits
// ----------------------------------------------------------------------------
module chs_transfer_command_issue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [chs_pkg::OFF_W-1:0]      byte_offset,
    input  logic [chs_pkg::LEN_W-1:0]      byte_length,
    input  logic [chs_pkg::SEC_W-1:0]      part_start_sector,
    input  logic [chs_pkg::SEC_W-1:0]      part_end_sector,
    input  logic                           drive_select,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     port_offset,
    output logic [7:0]                     reg_value,
    output logic [1:0]                     status,
    output logic [chs_pkg::BYTES_W-1:0]    byte_count,
    output logic                           last
);
    import chs_pkg::*;

    // configuration registers
    logic [SPT_W-1:0] spt_reg;
    logic [HPC_W-1:0] hpc_reg;
    logic             online_reg;

    // front to queue
    logic   push;
    entry_t wr_entry;
    // queue to back
    logic   pop;
    logic   fifo_full;
    logic   fifo_empty;
    entry_t rd_entry;
    // back to divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg    <= SPT_RESET;
            hpc_reg    <= HPC_RESET;
            online_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPT:    spt_reg    <= cfg_wdata;
                CFG_HPC:    hpc_reg    <= cfg_wdata[HPC_W-1:0];
                CFG_ONLINE: online_reg <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // classify and form the logical sector
    chs_front u_front (
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .byte_offset       (byte_offset),
        .byte_length       (byte_length),
        .part_start_sector (part_start_sector),
        .part_end_sector   (part_end_sector),
        .drive_select      (drive_select),
        .drive_online      (online_reg),
        .fifo_full         (fifo_full),
        .push              (push),
        .entry             (wr_entry)
    );

    // decouples request intake from the slow back end
    chs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // shared serial divider for both geometry steps
    chs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // chs conversion and write sequencing
    chs_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .fifo_empty         (fifo_empty),
        .entry              (rd_entry),
        .pop                (pop),
        .sectors_per_track  (spt_reg),
        .heads_per_cylinder (hpc_reg),
        .div_req            (div_req),
        .div_rsp            (div_rsp),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .port_offset        (port_offset),
        .reg_value          (reg_value),
        .status             (status),
        .byte_count         (byte_count),
        .last               (last)
    );

endmodule

// ----- tb/chs_transfer_command_issue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_transfer_command_issue_checker
// watches the request and result channels, computes the expected task-file
// writes for each accepted request and compares every accepted result
// ----------------------------------------------------------------------------
module chs_transfer_command_issue_checker
    import chs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   cmd,
    input  logic [OFF_W-1:0]       byte_offset,
    input  logic [LEN_W-1:0]       byte_length,
    input  logic [SEC_W-1:0]       part_start_sector,
    input  logic [SEC_W-1:0]       part_end_sector,
    input  logic                   drive_select,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [2:0]             port_offset,
    input  logic [7:0]             reg_value,
    input  logic [1:0]             status,
    input  logic [BYTES_W-1:0]     byte_count,
    input  logic                   last,
    output int                     fail_count,
    output int                     pending_writes,
    output int                     issued_seen,
    output int                     rejected_seen
);

    typedef struct packed {
        logic [2:0]         port;
        logic [7:0]         value;
        logic [1:0]         stat;
        logic [BYTES_W-1:0] bytes;
        logic               fin;
    } taskfile_write_t;

    taskfile_write_t expected_writes[$];

    logic [SPT_W-1:0] geo_spt;
    logic [HPC_W-1:0] geo_hpc;
    logic             geo_online;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic push_write(input logic [2:0] p, input logic [7:0] v,
                              input logic [1:0] s, input logic [BYTES_W-1:0] b,
                              input logic f);
        taskfile_write_t w;
        w.port  = p;
        w.value = v;
        w.stat  = s;
        w.bytes = b;
        w.fin   = f;
        expected_writes.push_back(w);
    endtask

    task automatic plan_request();
        logic [63:0] len, nsec, lsec, spt, hpc, cyl, sec, head, bytes;
        if (!geo_online)
        begin
            push_write(PORT_NONE, 8'd0, STATUS_OFFLINE, '0, 1'b1);
            return;
        end
        len  = 64'(byte_length);
        if (len > 64'(MAX_XFER_BYTES))
            len = 64'(MAX_XFER_BYTES);
        nsec = (len + SECTOR_BYTES - 1) / SECTOR_BYTES;
        lsec = 64'(byte_offset) / SECTOR_BYTES + 64'(part_start_sector);
        if (lsec >= 64'(part_end_sector))
        begin
            push_write(PORT_NONE, 8'd0, STATUS_PAST_END, '0, 1'b1);
            return;
        end
        spt  = (geo_spt == 0) ? 64'd1 : 64'(geo_spt);
        hpc  = (geo_hpc == 0) ? 64'd1 : 64'(geo_hpc);
        cyl  = lsec / (spt * hpc);
        sec  = lsec % spt + 1;
        head = (lsec / spt) % hpc;
        if (lsec + nsec > 64'(part_end_sector))
            nsec = 64'(part_end_sector) - lsec;
        bytes = nsec * SECTOR_BYTES;
        push_write(PORT_COUNT, nsec[7:0], STATUS_ISSUED, bytes[14:0], 1'b0);
        push_write(PORT_SECTOR, sec[7:0], STATUS_ISSUED, bytes[14:0], 1'b0);
        push_write(PORT_DRV_HEAD, 8'(DH_FIXED | (drive_select << 4) | head),
                   STATUS_ISSUED, bytes[14:0], 1'b0);
        push_write(PORT_CYL_LOW, cyl[7:0], STATUS_ISSUED, bytes[14:0], 1'b0);
        push_write(PORT_CYL_HIGH, cyl[15:8], STATUS_ISSUED, bytes[14:0], 1'b0);
        push_write(PORT_COMMAND, cmd ? CMD_WRITE : CMD_READ, STATUS_ISSUED,
                   bytes[14:0], 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        taskfile_write_t w;
        if (!rst_n)
        begin
            geo_spt    = SPT_RESET;
            geo_hpc    = HPC_RESET;
            geo_online = 1'b0;
            expected_writes.delete();
            fail_count     = 0;
            pending_writes = 0;
            issued_seen    = 0;
            rejected_seen  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                plan_request();
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                    report_mismatch("unexpected result port", port_offset, 0);
                else
                begin
                    w = expected_writes.pop_front();
                    if (port_offset !== w.port)
                        report_mismatch("port_offset", port_offset, w.port);
                    if (reg_value !== w.value)
                        report_mismatch("reg_value", reg_value, w.value);
                    if (status !== w.stat)
                        report_mismatch("status", status, w.stat);
                    if (byte_count !== w.bytes)
                        report_mismatch("byte_count", byte_count, w.bytes);
                    if (last !== w.fin)
                        report_mismatch("last", last, w.fin);
                    if (w.fin && w.stat == STATUS_ISSUED)
                        issued_seen++;
                    else if (w.fin)
                        rejected_seen++;
                end
            end
            pending_writes = expected_writes.size();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPT:    geo_spt    = cfg_wdata;
                    CFG_HPC:    geo_hpc    = cfg_wdata[HPC_W-1:0];
                    CFG_ONLINE: geo_online = cfg_wdata[0];
                    default:    ;
                endcase
            end
        end
    end

endmodule

// ----- tb/chs_transfer_command_issue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_transfer_command_issue_tb
// drives requests with random gaps and result stalls through several drive
// geometries; the checker predicts and compares every task-file write
// ----------------------------------------------------------------------------
module chs_transfer_command_issue_tb;
    import chs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic                  cmd;
    logic [OFF_W-1:0]      byte_offset;
    logic [LEN_W-1:0]      byte_length;
    logic [SEC_W-1:0]      part_start_sector;
    logic [SEC_W-1:0]      part_end_sector;
    logic                  drive_select;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            port_offset;
    logic [7:0]            reg_value;
    logic [1:0]            status;
    logic [BYTES_W-1:0]    byte_count;
    logic                  last;

    int  fail_count;
    int  pending_writes;
    int  issued_seen;
    int  rejected_seen;
    int  cycle_count;
    int  requests_sent;
    bit  stim_done;

    chs_transfer_command_issue DUT (.*);

    chs_transfer_command_issue_checker checker_inst (.*);

    // free-running clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // receiver stalls, changed at the falling edge only
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = 1'b1;
            // a stretch with no stalling at all
            n = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(1, 6);
            repeat (n) @(negedge clk);
            out_ready = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // let every expected write drain before touching the registers
    task automatic drain();
        while (pending_writes != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // one request transfer, valid held until accepted
    task automatic send_request(input logic c, input logic [31:0] off,
                                input logic [30:0] len, input logic [31:0] ps,
                                input logic [31:0] pe, input logic ds);
        repeat (gap_len()) @(negedge clk);
        cmd               = c;
        byte_offset       = off;
        byte_length       = len;
        part_start_sector = ps;
        part_end_sector   = pe;
        drive_select      = ds;
        in_valid          = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        requests_sent++;
    endtask

    // random request: most land inside the partition, some run past the end
    task automatic random_request();
        logic [31:0] ps, pe, off;
        logic [30:0] len;
        int sel;
        sel = $urandom_range(0, 9);
        ps  = (sel < 3) ? $urandom_range(0, 5000) : $urandom();
        off = (sel < 6) ? $urandom_range(0, 2000000) : $urandom();
        pe  = ps + (off >> 9) + $urandom_range(0, 64);
        if (sel == 9)
            pe = $urandom();
        case ($urandom_range(0, 3))
            0:       len = 31'($urandom());
            1:       len = 31'($urandom_range(0, 600));
            default: len = 31'($urandom_range(0, MAX_XFER_BYTES + 600));
        endcase
        send_request(1'($urandom_range(0, 1)), off, len, ps, pe,
                     1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic [7:0] spt_set[5] = '{8'd255, 8'd1, 8'd0, 8'd17, 8'd63};
        logic [7:0] hpc_set[5] = '{8'd16, 8'd1, 8'd0, 8'd31, 8'd7};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPT;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = 1'b0;
        byte_offset = '0;
        byte_length = '0;
        part_start_sector = '0;
        part_end_sector = '0;
        drive_select = 1'b0;
        cycle_count = 0;
        requests_sent = 0;
        stim_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drive offline straight after reset
        send_request(1'b0, 32'd0, 31'd512, 32'd0, 32'd100, 1'b0);
        send_request(1'b1, '1, '1, '1, '1, 1'b1);
        drain();
        write_reg(CFG_ONLINE, 8'd1);

        // directed: extremes, both commands, zero length, clipping, past end
        send_request(1'b0, 32'd0, 31'd0, 32'd0, 32'd1, 1'b0);
        send_request(1'b1, 32'd0, '1, 32'd0, '1, 1'b1);
        send_request(1'b0, 32'd1024, 31'd16384, 32'd10, 32'd12, 1'b0);
        send_request(1'b1, 32'd1023, 31'd1, 32'd0, 32'd1, 1'b1);
        send_request(1'b0, 32'd512, 31'd513, 32'd5, 32'd6, 1'b0);
        send_request(1'b0, '1, 31'd16385, '1, '1, 1'b0);
        send_request(1'b1, '1, 31'd4096, 32'hFFFF_FF00, '1, 1'b1);
        send_request(1'b0, 32'd0, 31'd512, 32'hFFF0_0000, '1, 1'b1);
        send_request(1'b1, 32'd0, 31'd100, 32'd4_000_000, 32'd4_000_100, 1'b0);
        send_request(1'b0, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, '1, 1'b0);
        send_request(1'b1, 32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555, '1, 1'b1);

        // sender holds off until everything has come back
        drain();

        // random part across geometries, one with the drive offline
        for (int g = 0; g < 5; g++)
        begin
            drain();
            write_reg(CFG_SPT, spt_set[g]);
            write_reg(CFG_HPC, hpc_set[g]);
            write_reg(CFG_ONLINE, (g == 3) ? 8'd0 : 8'd1);
            repeat ((g == 3) ? 20 : 65) random_request();
        end
        stim_done = 1'b1;
        drain();
        write_reg(CFG_ONLINE, 8'd1);
        repeat (100) @(negedge clk);

        $display("%0d requests: %0d issued, %0d rejected or offline",
                 requests_sent, issued_seen, rejected_seen);
        $display("geometries covered zero, minimum and maximum values");
        if (fail_count == 0 && pending_writes == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/chs_pkg.sv
hw/rtl/chs_front.sv
hw/rtl/chs_fifo.sv
hw/rtl/chs_divider.sv
hw/rtl/chs_back.sv
hw/rtl/chs_transfer_command_issue.sv
tb/chs_transfer_command_issue_checker.sv
tb/chs_transfer_command_issue_tb.sv
